FILE: rtl/bspld_pkg.sv
// Package with the shared types and constants of the button press detector.
`timescale 1ns / 1ps

package bspld_pkg;

   // Default width of the held-duration counter.
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Field widths of the stream payloads.
   localparam int DEBOUNCE_WIDTH = 8;
   localparam int LONG_WIDTH     = 16;
   localparam int HELD_WIDTH     = 16;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 24;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TICKS   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TICKS = 1'd1;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET   = 8'd10;
   localparam logic [LONG_WIDTH-1:0]     LONG_PRESS_RESET = 16'd3000;

   localparam logic [DEBOUNCE_WIDTH-1:0] STABLE_MAX = '1;

   typedef enum logic [1:0] {
      EVENT_NONE  = 2'd0,
      EVENT_SHORT = 2'd1,
      EVENT_LONG  = 2'd2
   } press_event_type;

   // Latched press state carried between the step logic and its registers.
   typedef struct packed {
      logic pressed;
      logic long_flag;
   } press_flags_type;

endpackage

FILE: rtl/bspld_step.sv
// Next-state and result logic for one millisecond tick of the press detector.
`timescale 1ns / 1ps

module bspld_step #(
   parameter int COUNT_WIDTH = bspld_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                    button_level,
   input  logic [bspld_pkg::DEBOUNCE_WIDTH-1:0]    debounce_ticks,
   input  logic [bspld_pkg::LONG_WIDTH-1:0]        long_press_ticks,
   input  bspld_pkg::press_flags_type              flags_cur,
   input  logic [COUNT_WIDTH-1:0]                  hold_cur,
   input  logic [bspld_pkg::DEBOUNCE_WIDTH-1:0]    stable_cur,
   output bspld_pkg::press_flags_type              flags_next,
   output logic [COUNT_WIDTH-1:0]                  hold_next,
   output logic [bspld_pkg::DEBOUNCE_WIDTH-1:0]    stable_next,
   output bspld_pkg::press_event_type              press_event,
   output logic                                    press_held,
   output logic                                    long_reached,
   output logic [bspld_pkg::HELD_WIDTH-1:0]        held_ticks
);

   // Comparisons run at the wider of the counter and the 16-bit fields.
   localparam int CMP_WIDTH = (COUNT_WIDTH > bspld_pkg::LONG_WIDTH) ?
                              COUNT_WIDTH : bspld_pkg::LONG_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] HOLD_MAX = '1;
   localparam logic [CMP_WIDTH-1:0] SHOWN_MAX =
      CMP_WIDTH'({bspld_pkg::HELD_WIDTH{1'b1}});

   logic [bspld_pkg::DEBOUNCE_WIDTH-1:0] stable_inc;
   logic                                 settled;
   logic [COUNT_WIDTH-1:0]               hold_inc;
   logic [CMP_WIDTH-1:0]                 hold_ext;
   logic                                 long_now;
   logic                                 release_seen;

   always_comb begin
      // A zero debounce setting is met by the very first disagreeing tick.
      stable_inc = (stable_cur == bspld_pkg::STABLE_MAX) ?
                   stable_cur : stable_cur + 1'b1;
      settled    = (stable_inc >= debounce_ticks);

      hold_inc = (hold_cur == HOLD_MAX) ? hold_cur : hold_cur + 1'b1;
      hold_ext = CMP_WIDTH'(hold_inc);
      long_now = flags_cur.long_flag ||
                 (hold_ext >= CMP_WIDTH'(long_press_ticks));

      flags_next   = flags_cur;
      hold_next    = hold_cur;
      stable_next  = stable_cur;
      press_event  = bspld_pkg::EVENT_NONE;
      release_seen = 1'b0;

      if (!flags_cur.pressed) begin
         if (button_level) begin
            if (settled) begin
               flags_next.pressed   = 1'b1;
               flags_next.long_flag = 1'b0;
               hold_next            = '0;
               stable_next          = '0;
            end else begin
               stable_next = stable_inc;
            end
         end else begin
            stable_next = '0;
         end
      end else begin
         // The release debounce ticks count towards the held duration as well.
         hold_next            = hold_inc;
         flags_next.long_flag = long_now;
         if (button_level) begin
            stable_next = '0;
         end else if (settled) begin
            release_seen         = 1'b1;
            press_event          = long_now ? bspld_pkg::EVENT_LONG :
                                              bspld_pkg::EVENT_SHORT;
            flags_next.pressed   = 1'b0;
            flags_next.long_flag = 1'b0;
            stable_next          = '0;
         end else begin
            stable_next = stable_inc;
         end
      end

      press_held   = flags_next.pressed;
      long_reached = flags_next.pressed && flags_next.long_flag;
      hold_ext     = CMP_WIDTH'(hold_next);
      held_ticks   = (hold_ext > SHOWN_MAX) ? {bspld_pkg::HELD_WIDTH{1'b1}} :
                     hold_ext[bspld_pkg::HELD_WIDTH-1:0];

      // The final duration is reported on the release tick, then cleared.
      if (release_seen) begin
         hold_next = '0;
      end
   end

endmodule

FILE: rtl/button_short_long_press_detector_unit.sv
// Top level of the debounced button detector with short and long press events.
`timescale 1ns / 1ps

// Each req transaction is one millisecond tick carrying the sampled button
// level, and each one yields exactly one rsp transaction via the result register. The
// block takes a tick in every cycle: the step logic is a single pass from the
// current state registers to the result register, and req_tready stays high
// as long as the result register is empty or being taken in the same cycle.
// Press and release are accepted after debounce_ticks consecutive ticks; the
// release tick carries a short or long event and the final held duration.
// Configuration writes are taken at once and should only happen while idle.

module button_short_long_press_detector_unit #(
   parameter int COUNT_WIDTH = bspld_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [0] button_level, [7:1] zero
   input  logic [bspld_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [1:0] press_event, [2] press_held, [3] long_reached, [19:4] held_ticks,
   // [23:20] zero
   output logic [bspld_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bspld_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bspld_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   logic [bspld_pkg::DEBOUNCE_WIDTH-1:0] debounce_ff;
   logic [bspld_pkg::LONG_WIDTH-1:0]     long_press_ff;

   bspld_pkg::press_flags_type           flags_ff;
   bspld_pkg::press_flags_type           flags_in;
   logic [COUNT_WIDTH-1:0]               hold_ff;
   logic [COUNT_WIDTH-1:0]               hold_in;
   logic [bspld_pkg::DEBOUNCE_WIDTH-1:0] stable_ff;
   logic [bspld_pkg::DEBOUNCE_WIDTH-1:0] stable_in;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [bspld_pkg::RSP_DATA_WIDTH-1:0] rsp_data_ff;
   logic [bspld_pkg::RSP_DATA_WIDTH-1:0] rsp_data_in;

   bspld_pkg::press_event_type           press_event;
   logic                                 press_held;
   logic                                 long_reached;
   logic [bspld_pkg::HELD_WIDTH-1:0]     held_ticks;
   logic                                 req_take;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   bspld_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .button_level     (req_tdata[0]),
      .debounce_ticks   (debounce_ff),
      .long_press_ticks (long_press_ff),
      .flags_cur        (flags_ff),
      .hold_cur         (hold_ff),
      .stable_cur       (stable_ff),
      .flags_next       (flags_in),
      .hold_next        (hold_in),
      .stable_next      (stable_in),
      .press_event      (press_event),
      .press_held       (press_held),
      .long_reached     (long_reached),
      .held_ticks       (held_ticks)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, held_ticks, long_reached, press_held,
                         press_event};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= bspld_pkg::DEBOUNCE_RESET;
         long_press_ff <= bspld_pkg::LONG_PRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bspld_pkg::CSR_DEBOUNCE_TICKS: begin
               debounce_ff <= csr_data[bspld_pkg::DEBOUNCE_WIDTH-1:0];
            end
            bspld_pkg::CSR_LONG_PRESS_TICKS: begin
               long_press_ff <= csr_data[bspld_pkg::LONG_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         hold_ff      <= '0;
         stable_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            flags_ff  <= flags_in;
            hold_ff   <= hold_in;
            stable_ff <= stable_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
